>>> design/pif_pkg.sv
// ----------------------------------------------------------------------------
// pif_pkg
// Shared types, constants and the digit character table of the printf
// integer formatter.
// ----------------------------------------------------------------------------
package pif_pkg;

  localparam int INT_BITS    = 16;
  localparam int MAX_DIGITS  = 32;
  localparam int DIGIT_STORE = 33;
  localparam int WIDTH_CAP   = (MAX_DIGITS - 2 > 31) ? 31 : MAX_DIGITS - 2;

  localparam int FW_W  = 5;
  localparam int ND_W  = $clog2(DIGIT_STORE + 1);
  localparam int IDX_W = $clog2(DIGIT_STORE);
  localparam int REM_W = $clog2(DIGIT_STORE + 2);

  // Unsigned division by ten: q = (v * DEC_RECIP) >> DEC_SHIFT for any 32-bit v.
  localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
  localparam int          DEC_SHIFT = 35;

  localparam logic [32:0] INT_SPAN  = 33'(1) << INT_BITS;
  localparam logic [32:0] LONG_SPAN = 33'(1) << 32;
  localparam logic [31:0] INT_MASK  = 32'(INT_SPAN - 33'(1));

  localparam logic [7:0] DIGIT_TABLE [32] = '{
    "0", "1", "2", "3", "4", "5", "6", "7",
    "8", "9", "a", "b", "c", "d", "e", "f",
    "0", "1", "2", "3", "4", "5", "6", "7",
    "8", "9", "A", "B", "C", "D", "E", "F"
  };

  typedef struct packed {
    logic [7:0]  fmt_char;
    logic [31:0] arg_word;
  } pif_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } pif_out_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_SINGLE,
    KIND_CONV
  } kind_t;

  typedef enum logic [1:0] {
    RAD_BIN,
    RAD_OCT,
    RAD_DEC,
    RAD_HEX
  } radix_t;

  typedef enum logic [2:0] {
    SRC_SINGLE,
    SRC_SPACE,
    SRC_ZERO,
    SRC_MINUS,
    SRC_DIGIT
  } src_t;

  typedef struct packed {
    logic accept;
    logic mul;
    logic digit;
    logic prep;
    logic emit;
    src_t src;
  } pif_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  dec;
    logic  more;
    logic  zeros;
    logic  ljust;
    logic  neg;
    logic  pad_zero;
    logic  pad_one;
    logic  dig_last;
    logic  out_free;
  } pif_stat_t;

  function automatic logic [7:0] digit_char(input logic upper, input logic [3:0] d);
    return DIGIT_TABLE[{upper, d}];
  endfunction

endpackage

>>> design/pif_ctrl.sv
// ----------------------------------------------------------------------------
// pif_ctrl
// Sequencer of the formatter: accepts items, steps the digit extraction and
// walks the output phases (padding, sign, digits) one character at a time.
// ----------------------------------------------------------------------------
module pif_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pif_pkg::pif_stat_t  stat,
  output pif_pkg::pif_cmd_t   cmd
);
  import pif_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ONE,
    S_MUL,
    S_DIG,
    S_PREP,
    S_PADL,
    S_SIGN,
    S_ZPAD,
    S_DIGS,
    S_PADR
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.src    = SRC_SINGLE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (stat.kind)
            KIND_SINGLE: state_next = S_ONE;
            KIND_CONV:   state_next = S_MUL;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_ONE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.src    = SRC_SINGLE;
          state_next = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIG;
      end
      S_DIG: begin
        cmd.digit = 1'b1;
        if (stat.more) begin
          state_next = stat.dec ? S_MUL : S_DIG;
        end else begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = stat.zeros ? S_SIGN : S_PADL;
      end
      S_PADL: begin
        if (stat.ljust || stat.pad_zero) begin
          state_next = S_SIGN;
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.src  = SRC_SPACE;
          if (stat.pad_one) begin
            state_next = S_SIGN;
          end
        end
      end
      S_SIGN: begin
        if (!stat.neg) begin
          state_next = stat.zeros ? S_ZPAD : S_DIGS;
        end else if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.src    = SRC_MINUS;
          state_next = stat.zeros ? S_ZPAD : S_DIGS;
        end
      end
      S_ZPAD: begin
        if (stat.pad_zero) begin
          state_next = S_DIGS;
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.src  = SRC_ZERO;
          if (stat.pad_one) begin
            state_next = S_DIGS;
          end
        end
      end
      S_DIGS: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.src  = SRC_DIGIT;
          if (stat.dig_last) begin
            state_next = stat.zeros ? S_IDLE : S_PADR;
          end
        end
      end
      S_PADR: begin
        if (!stat.ljust || stat.pad_zero) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.src  = SRC_SPACE;
          if (stat.pad_one) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> design/pif_dpath.sv
// ----------------------------------------------------------------------------
// pif_dpath
// Datapath of the formatter: format parser state, argument preparation,
// digit extraction into a digit memory, padding counters and the output
// register.
// ----------------------------------------------------------------------------
module pif_dpath (
  input  logic                clk,
  input  logic                rst,
  input  pif_pkg::pif_in_t    in_data,
  input  pif_pkg::pif_cmd_t   cmd,
  output pif_pkg::pif_stat_t  stat,
  input  logic                out_ready,
  output logic                out_valid,
  output pif_pkg::pif_out_t   out_data
);
  import pif_pkg::*;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PCT   = "%";
  localparam logic [7:0] CH_L     = "l";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_D     = "d";
  localparam logic [7:0] CH_U     = "u";
  localparam logic [7:0] CH_LX    = "x";
  localparam logic [7:0] CH_UX    = "X";
  localparam logic [7:0] CH_O     = "o";
  localparam logic [7:0] CH_B     = "b";
  localparam logic [7:0] CH_P     = "p";
  localparam logic [7:0] CH_C     = "c";

  // Parser state.
  logic            in_spec;
  logic            long_mode;
  logic [FW_W-1:0] field_width;
  logic            zero_fill;
  logic            left_justify;

  // Conversion registers.
  logic [31:0]      val;
  radix_t           radix;
  logic             upper;
  logic             neg;
  logic [FW_W-1:0]  conv_width;
  logic             conv_zeros;
  logic             conv_lj;
  logic [7:0]       single_char;
  logic [63:0]      prod;
  logic [ND_W-1:0]  nd;
  logic [IDX_W-1:0] rd_idx;
  logic [7:0]       rd_data;
  logic [FW_W-1:0]  pad;
  logic [REM_W-1:0] remain;
  logic [7:0]       digit_mem [DIGIT_STORE];

  // Decode of the incoming character.
  logic [7:0]  c;
  logic [31:0] arg;
  kind_t       kind;
  radix_t      radix_sel;
  logic        upper_sel;
  logic        signed_sel;
  logic        is_ptr;
  logic [7:0]  echo;

  assign c   = in_data.fmt_char;
  assign arg = in_data.arg_word;

  always_comb begin
    kind       = KIND_SINGLE;
    radix_sel  = RAD_DEC;
    upper_sel  = 1'b0;
    signed_sel = 1'b0;
    is_ptr     = 1'b0;
    echo       = c;
    if (c == CH_NUL) begin
      kind = KIND_NONE;
    end else if (!in_spec) begin
      kind = (c == CH_PCT) ? KIND_NONE : KIND_SINGLE;
    end else begin
      case (c) inside
        [CH_ZERO:CH_NINE], CH_L, CH_MINUS: kind = KIND_NONE;
        CH_D: begin
          kind       = KIND_CONV;
          signed_sel = 1'b1;
        end
        CH_U: kind = KIND_CONV;
        CH_LX: begin
          kind      = KIND_CONV;
          radix_sel = RAD_HEX;
        end
        CH_UX: begin
          kind      = KIND_CONV;
          radix_sel = RAD_HEX;
          upper_sel = 1'b1;
        end
        CH_O: begin
          kind      = KIND_CONV;
          radix_sel = RAD_OCT;
        end
        CH_B: begin
          kind      = KIND_CONV;
          radix_sel = RAD_BIN;
        end
        CH_P: begin
          kind      = KIND_CONV;
          radix_sel = RAD_HEX;
          upper_sel = 1'b1;
          is_ptr    = 1'b1;
        end
        CH_C: echo = arg[7:0];
        default: kind = KIND_SINGLE;
      endcase
    end
  end

  // Width digit accumulation, saturating at the cap.
  logic [7:0] c_off;
  logic [8:0] fw_sum;
  logic [FW_W-1:0] fw_next;

  assign c_off   = c - CH_ZERO;
  assign fw_sum  = ({4'b0, field_width} << 3) + ({4'b0, field_width} << 1)
                 + {5'b0, c_off[3:0]};
  assign fw_next = (fw_sum > 9'(WIDTH_CAP)) ? FW_W'(WIDTH_CAP) : fw_sum[FW_W-1:0];

  // Argument preparation: select the active bits and take the magnitude.
  logic        eff_long;
  logic [31:0] base;
  logic        sign_bit;
  logic        make_neg;
  logic [32:0] span;
  logic [31:0] mag;

  assign eff_long = long_mode || is_ptr;
  assign base     = eff_long ? arg : (arg & INT_MASK);
  assign sign_bit = eff_long ? arg[31] : arg[INT_BITS-1];
  assign make_neg = signed_sel && sign_bit;
  assign span     = eff_long ? LONG_SPAN : INT_SPAN;
  assign mag      = make_neg ? 32'(span - {1'b0, base}) : base;

  // One digit per step; decimal uses the product registered in the step before.
  logic [63:0]     prod_calc;
  logic [31:0]     quot10;
  logic [31:0]     times10;
  logic [31:0]     rem10;
  logic [3:0]      dig;
  logic [31:0]     val_next;
  logic [ND_W-1:0] nd_inc;

  assign prod_calc = val * DEC_RECIP;
  assign quot10    = 32'(prod[63:DEC_SHIFT]);
  assign times10   = (quot10 << 3) + (quot10 << 1);
  assign rem10     = val - times10;
  assign nd_inc    = nd + 1'b1;

  always_comb begin
    case (radix)
      RAD_BIN: begin
        dig      = {3'b0, val[0]};
        val_next = val >> 1;
      end
      RAD_OCT: begin
        dig      = {1'b0, val[2:0]};
        val_next = val >> 3;
      end
      RAD_HEX: begin
        dig      = val[3:0];
        val_next = val >> 4;
      end
      default: begin
        dig      = rem10[3:0];
        val_next = quot10;
      end
    endcase
  end

  // Padding and character count, worked out once the digits are known.
  logic [REM_W-1:0] len;
  logic [REM_W-1:0] width_ext;
  logic [FW_W-1:0]  pad_calc;
  logic [REM_W-1:0] rem_calc;

  assign len       = REM_W'(nd) + REM_W'(neg);
  assign width_ext = REM_W'(conv_width);
  assign pad_calc  = (width_ext > len) ? FW_W'(width_ext - len) : '0;
  assign rem_calc  = (width_ext > len) ? width_ext : len;

  // The digit memory is read at the next index so rd_data tracks rd_idx.
  logic [IDX_W-1:0] rd_idx_next;

  always_comb begin
    if (cmd.prep) begin
      rd_idx_next = IDX_W'(nd - 1'b1);
    end else if (cmd.emit && cmd.src == SRC_DIGIT) begin
      rd_idx_next = rd_idx - 1'b1;
    end else begin
      rd_idx_next = rd_idx;
    end
  end

  logic [7:0] ch;

  always_comb begin
    case (cmd.src)
      SRC_SINGLE: ch = single_char;
      SRC_SPACE:  ch = CH_SPACE;
      SRC_ZERO:   ch = CH_ZERO;
      SRC_MINUS:  ch = CH_MINUS;
      SRC_DIGIT:  ch = rd_data;
      default:    ch = single_char;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_spec      <= 1'b0;
      long_mode    <= 1'b0;
      field_width  <= '0;
      zero_fill    <= 1'b0;
      left_justify <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (c == CH_NUL) begin
          in_spec <= 1'b0;
        end else if (!in_spec) begin
          if (c == CH_PCT) begin
            in_spec      <= 1'b1;
            long_mode    <= 1'b0;
            field_width  <= '0;
            zero_fill    <= 1'b0;
            left_justify <= 1'b0;
          end
        end else begin
          case (c) inside
            CH_L: long_mode <= 1'b1;
            [CH_ZERO:CH_NINE]: begin
              if (field_width == '0 && c == CH_ZERO) begin
                zero_fill <= 1'b1;
              end else begin
                field_width <= fw_next;
              end
            end
            CH_MINUS: left_justify <= 1'b1;
            default:  in_spec <= 1'b0;
          endcase
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      val         <= mag;
      radix       <= radix_sel;
      upper       <= upper_sel;
      neg         <= make_neg;
      conv_width  <= is_ptr ? FW_W'(8) : field_width;
      conv_zeros  <= is_ptr || zero_fill;
      conv_lj     <= left_justify;
      single_char <= echo;
      nd          <= '0;
      remain      <= REM_W'(1);
    end
    if (cmd.mul) begin
      prod <= prod_calc;
    end
    if (cmd.digit) begin
      digit_mem[nd[IDX_W-1:0]] <= digit_char(upper, dig);
      val <= val_next;
      nd  <= nd_inc;
    end
    if (cmd.prep) begin
      pad    <= pad_calc;
      remain <= rem_calc;
    end
    if (cmd.emit) begin
      out_data <= '{out_char: ch, last: (remain == REM_W'(1))};
      remain   <= remain - 1'b1;
      if (cmd.src == SRC_SPACE || cmd.src == SRC_ZERO) begin
        pad <= pad - 1'b1;
      end
    end
    rd_idx  <= rd_idx_next;
    rd_data <= digit_mem[rd_idx_next];
  end

  assign stat.kind     = kind;
  assign stat.dec      = (radix == RAD_DEC);
  assign stat.more     = (val_next != '0) && (nd_inc < ND_W'(DIGIT_STORE));
  assign stat.zeros    = conv_zeros;
  assign stat.ljust    = conv_lj;
  assign stat.neg      = neg;
  assign stat.pad_zero = (pad == '0);
  assign stat.pad_one  = (pad == FW_W'(1));
  assign stat.dig_last = (rd_idx == '0);
  assign stat.out_free = !out_valid || out_ready;

`ifndef NO_ASSERTIONS
  // A character is only loaded when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("character loaded while output register is occupied");

  // Every emitted character is still owed by the current item.
  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (remain != '0))
    else $error("more characters emitted than the item owes");

  // The character count covers padding, sign and digits exactly.
  a_prep_count: assert property (@(posedge clk) disable iff (rst)
    cmd.prep |=> (remain == REM_W'(pad) + REM_W'(neg) + REM_W'(nd)))
    else $error("character count does not match padding, sign and digits");

  // The digit store never overflows.
  a_nd_range: assert property (@(posedge clk) disable iff (rst)
    cmd.digit |-> (nd < ND_W'(DIGIT_STORE)))
    else $error("digit store overflow");
`endif

endmodule

>>> design/printf_integer_formatter_top.sv
// ----------------------------------------------------------------------------
// printf_integer_formatter_top
// A pass-through or %c character goes via state S_ONE to the output register; a
// flag character gives no output. A conversion runs one multiply step, then one
// extraction step per hex/octal/binary digit, or a multiply and an extraction step
// per decimal digit (multiply, then quotient and remainder), then a setup step and
// the output phases, one character at a time and held while the output stalls.
// One item is in work at a time. Synchronous reset clears the parser state.
// ----------------------------------------------------------------------------
module printf_integer_formatter_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pif_pkg::pif_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pif_pkg::pif_out_t  out_data
);
  import pif_pkg::*;

  pif_cmd_t  cmd;
  pif_stat_t stat;

  pif_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pif_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
